// ===== design/phtm_pkg.sv =====
// Shared types, constants and helper functions for the pipeline hazard timing model.
// Used by the stage file, the sequencer and the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package phtm_pkg;

	localparam logic [1:0] MODE_IDEAL = 2'd0;
	localparam logic [1:0] MODE_STALL = 2'd1;
	localparam logic [1:0] MODE_FWD   = 2'd2;

	localparam logic CMD_ISSUE = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int FLAG_CTRL = 0;
	localparam int FLAG_LOAD = 1;

	localparam int MAX_RESULTS = 12;
	localparam int REP_W       = 4;

	typedef struct packed {
		logic [1:0] flags;
		logic [9:0] dests;
		logic [9:0] srcs;
	} instr_t;

	typedef struct packed {
		logic   apply;
		logic   enter;
		instr_t instr;
	} cmd_t;

	typedef struct packed {
		logic hold;
		logic enter_ok;
		logic any_valid;
	} status_t;

	function automatic logic regs_overlap(input logic [9:0] srcs, input logic [9:0] dests);
		logic hit;
		hit = 1'b0;
		if (srcs[4] && dests[4] && (srcs[3:0] == dests[3:0])) hit = 1'b1;
		if (srcs[4] && dests[9] && (srcs[3:0] == dests[8:5])) hit = 1'b1;
		if (srcs[9] && dests[4] && (srcs[8:5] == dests[3:0])) hit = 1'b1;
		if (srcs[9] && dests[9] && (srcs[8:5] == dests[8:5])) hit = 1'b1;
		return hit;
	endfunction

endpackage

`default_nettype wire

// ===== design/phtm_stage_file.sv =====
// Pipeline stage registers with the hazard compare unit and the control-flow block check.
// Depends on phtm_pkg; driven by the sequencer through a move vector and a command struct.
`timescale 1ns / 1ps
`default_nettype none

module phtm_stage_file import phtm_pkg::*; #(
	parameter int STAGES             = 5,
	parameter int READ_STAGE         = 1,
	parameter int FORWARD_READ_STAGE = 2,
	parameter int KNOW_PC_STAGE      = 2,
	parameter int ALU_PRODUCE_STAGE  = 2,
	parameter int MEM_PRODUCE_STAGE  = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        mode,
	input  wire cmd_t              cmd,
	input  wire logic [STAGES-1:0] move,
	output logic      [STAGES-1:0] valid,
	output logic      [15:0]       last_seq,
	output status_t                status
);

	localparam int RD_IDX  = (READ_STAGE < STAGES) ? READ_STAGE : 0;
	localparam int FW_IDX  = (FORWARD_READ_STAGE < STAGES) ? FORWARD_READ_STAGE : 0;
	localparam int KP_LAST = (KNOW_PC_STAGE < STAGES) ? KNOW_PC_STAGE : STAGES - 1;

	logic [STAGES-1:0] valid_q;
	logic [15:0]       seq_q   [STAGES];
	logic [9:0]        srcs_q  [STAGES];
	logic [9:0]        dests_q [STAGES];
	logic [1:0]        flags_q [STAGES];
	logic [15:0]       next_seq_q;

	logic [STAGES-1:0] post_valid;
	logic [9:0]        post_dests [STAGES];
	logic [1:0]        post_flags [STAGES];
	logic              hold_r;
	logic              hold_f;
	logic              ctrl_blk;

	// Stage contents as they stand once the moves decided so far have taken place.
	always_comb begin
		post_valid[0] = valid_q[0] & ~move[0];
		post_dests[0] = dests_q[0];
		post_flags[0] = flags_q[0];
		for (int j = 1; j < STAGES; j++) begin
			post_valid[j] = move[j-1] | (valid_q[j] & ~move[j]);
			post_dests[j] = move[j-1] ? dests_q[j-1] : dests_q[j];
			post_flags[j] = move[j-1] ? flags_q[j-1] : flags_q[j];
		end
	end

	always_comb begin
		hold_r = 1'b0;
		for (int j = READ_STAGE + 1; j < STAGES; j++) begin
			if (post_valid[j] && regs_overlap(srcs_q[RD_IDX], post_dests[j])) hold_r = 1'b1;
		end
	end

	always_comb begin
		hold_f = 1'b0;
		for (int j = FORWARD_READ_STAGE + 1; j < STAGES; j++) begin
			if (post_valid[j] && regs_overlap(srcs_q[FW_IDX], post_dests[j])) begin
				if (post_flags[j][FLAG_LOAD]) begin
					if (j <= MEM_PRODUCE_STAGE + 1) hold_f = 1'b1;
				end else if (j <= ALU_PRODUCE_STAGE + 1) begin
					hold_f = 1'b1;
				end
			end
		end
	end

	always_comb begin
		ctrl_blk = 1'b0;
		for (int i = 0; i <= KP_LAST; i++) begin
			if (post_valid[i] && post_flags[i][FLAG_CTRL]) ctrl_blk = 1'b1;
		end
	end

	assign status.hold      = (mode == MODE_STALL) ? hold_r : hold_f;
	assign status.enter_ok  = ~post_valid[0] & ((mode == MODE_IDEAL) | ~ctrl_blk);
	assign status.any_valid = |valid_q;

	assign valid    = valid_q;
	assign last_seq = seq_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			next_seq_q <= '0;
		end else if (cmd.apply) begin
			valid_q <= {post_valid[STAGES-1:1], post_valid[0] | cmd.enter};
			if (cmd.enter) begin
				next_seq_q <= next_seq_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int j = 1; j < STAGES; j++) begin
				if (move[j-1]) begin
					seq_q[j]   <= seq_q[j-1];
					srcs_q[j]  <= srcs_q[j-1];
					dests_q[j] <= dests_q[j-1];
					flags_q[j] <= flags_q[j-1];
				end
			end
			if (cmd.enter) begin
				seq_q[0]   <= next_seq_q;
				srcs_q[0]  <= cmd.instr.srcs;
				dests_q[0] <= cmd.instr.dests;
				flags_q[0] <= cmd.instr.flags;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/phtm_seq.sv =====
// Sequencer: walks the stages one per cycle, held while the output stalls, to decide moves,
// applies them, counts cycles and delivers retirement beats. Depends on phtm_pkg and the status of phtm_stage_file.
`timescale 1ns / 1ps
`default_nettype none

module phtm_seq import phtm_pkg::*; #(
	parameter int STAGES             = 5,
	parameter int READ_STAGE         = 1,
	parameter int FORWARD_READ_STAGE = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        mode,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              s_cmd,
	input  wire instr_t            s_instr,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [47:0]       m_tdata,
	output logic                   m_tlast,
	input  wire logic [STAGES-1:0] valid,
	input  wire logic [15:0]       last_seq,
	input  wire status_t           status,
	output cmd_t                   cmd,
	output logic      [STAGES-1:0] move
);

	localparam int IDX_W      = $clog2(STAGES);
	localparam int STEP_LIMIT = 4 * STAGES + 4;
	localparam int CLK_W      = $clog2(STEP_LIMIT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAGES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STAGES-1:0] move_q;
	logic              broken_q;
	logic [CLK_W-1:0]  clk_cnt_q;
	logic [REP_W-1:0]  rep_q;
	logic [31:0]       cycle_q;
	logic              drain_q;
	logic              pend_q;
	logic              out_valid_q;
	instr_t            instr_q;
	logic [15:0]       pend_seq_q;
	logic [31:0]       pend_time_q;
	logic [47:0]       out_data_q;
	logic              out_last_q;

	logic              out_free;
	logic              ret;
	logic              rep_ok;
	logic [STAGES-1:0] busy_above;
	logic              cur_v;
	logic              cur_b;
	logic              at_hold;
	logic              gated;
	logic              stall_here;
	logic              mv;
	logic              brk;
	logic              wait_ret;
	logic              capture;
	logic              push;
	logic              limit_hit;
	logic              accept;

	assign accept     = s_tvalid & s_tready;
	assign out_free   = ~out_valid_q | m_tready;
	assign ret        = valid[LAST_IDX];
	assign rep_ok     = rep_q < REP_W'(MAX_RESULTS);
	assign busy_above = (valid & ~move_q) >> 1;
	assign cur_v      = valid[idx_q];
	assign cur_b      = busy_above[idx_q];
	assign at_hold    = (mode == MODE_STALL) ? (int'(idx_q) == READ_STAGE)
	                                         : (int'(idx_q) == FORWARD_READ_STAGE);
	assign gated      = mode != MODE_IDEAL;
	assign stall_here = gated & at_hold & status.hold;
	assign mv         = cur_v & ~broken_q & (~gated | (~cur_b & ~stall_here));
	assign brk        = cur_v & ~broken_q & gated & ~cur_b & stall_here;
	assign wait_ret   = ret & rep_ok & pend_q & ~out_free;
	assign capture    = (state_q == ST_WALK) & (idx_q == LAST_IDX) & ret & rep_ok & ~wait_ret;
	assign push       = (capture & pend_q) | ((state_q == ST_FLUSH) & pend_q & out_free);
	assign limit_hit  = clk_cnt_q == CLK_W'(STEP_LIMIT);

	assign s_tready  = state_q == ST_IDLE;
	assign cmd.apply = state_q == ST_APPLY;
	assign cmd.enter = (state_q == ST_APPLY) & (drain_q == CMD_ISSUE) & status.enter_ok;
	assign cmd.instr = instr_q;
	assign move      = move_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tlast   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			move_q      <= '0;
			broken_q    <= 1'b0;
			clk_cnt_q   <= '0;
			rep_q       <= '0;
			cycle_q     <= '0;
			drain_q     <= CMD_ISSUE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						drain_q   <= s_cmd;
						clk_cnt_q <= '0;
						rep_q     <= '0;
						state_q   <= ST_START;
					end
				end
				ST_START: begin
					if (limit_hit || ((drain_q == CMD_DRAIN) && !status.any_valid)) begin
						state_q <= ST_FLUSH;
					end else begin
						move_q   <= '0;
						broken_q <= 1'b0;
						idx_q    <= LAST_IDX;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (idx_q == LAST_IDX) begin
						if (!wait_ret) begin
							if (capture) begin
								pend_q <= 1'b1;
								rep_q  <= rep_q + REP_W'(1);
							end
							move_q[idx_q] <= ret;
							idx_q         <= idx_q - IDX_W'(1);
						end
					end else begin
						move_q[idx_q] <= mv;
						if (brk) broken_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= ST_APPLY;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
						end
					end
				end
				ST_APPLY: begin
					move_q    <= '0;
					cycle_q   <= cycle_q + 32'd1;
					clk_cnt_q <= clk_cnt_q + CLK_W'(1);
					state_q   <= cmd.enter ? ST_FLUSH : ST_START;
				end
				ST_FLUSH: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) instr_q <= s_instr;
		if (push) begin
			out_data_q <= {pend_time_q, pend_seq_q};
			out_last_q <= state_q == ST_FLUSH;
		end
		if (capture) begin
			pend_seq_q  <= last_seq;
			pend_time_q <= cycle_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/pipeline_hazard_timing_model.sv =====
// Top level of the pipeline hazard timing model: register port, stage file and sequencer.
// Depends on phtm_pkg, phtm_stage_file and phtm_seq.
`timescale 1ns / 1ps
`default_nettype none

// Cycle model of an in-order pipeline with read-after-write and control-flow hazards.
// An issue beat advances the modeled pipeline clock by clock until the instruction
// enters stage 0 or the step limit is hit; a drain beat advances it until every stage
// is empty or the step limit is hit. Each retiring instruction, up to MAX_RESULTS per
// input beat, produces one output beat with its sequence number and completion cycle,
// and the final beat of an input carries tlast. One modeled clock is a start state, a
// walk over the stages from the last to the first (one stage a cycle, holding at the
// last stage while an earlier result waits for the output), and an apply state that
// applies the moves. A flush state then hands off any pending result before the block
// returns to idle; a stalled output holds the walk and this hand-off.
// The user must write the mode register only while no beat is in progress; the block
// itself does not enforce this.
module pipeline_hazard_timing_model import phtm_pkg::*; #(
	parameter int STAGES             = 5,
	parameter int READ_STAGE         = 1,
	parameter int FORWARD_READ_STAGE = 2,
	parameter int KNOW_PC_STAGE      = 2,
	parameter int ALU_PRODUCE_STAGE  = 2,
	parameter int MEM_PRODUCE_STAGE  = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// src_a[3:0], src_a_used[4], src_b[8:5], src_b_used[9], dest_a[13:10],
	// dest_a_used[14], dest_b[18:15], dest_b_used[19], is_control[20],
	// reads_memory[21], zero padding[23:22]
	input  wire logic [23:0] s_tdata,
	// command[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// instr_number[15:0], completion_time[47:16]
	output logic      [47:0] m_tdata,
	output logic             m_tlast
);

	localparam logic REG_MODE = 1'b0;

	logic              cfg_wr;
	logic [1:0]        mode_q;
	instr_t            s_instr;
	cmd_t              cmd;
	status_t           status;
	logic [STAGES-1:0] stage_valid;
	logic [STAGES-1:0] move;
	logic [15:0]       last_seq;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDEAL;
		end else if (cfg_wr && (paddr[2] == REG_MODE)) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign s_instr.srcs  = s_tdata[9:0];
	assign s_instr.dests = s_tdata[19:10];
	assign s_instr.flags = s_tdata[21:20];

	phtm_stage_file #(
		.STAGES             (STAGES),
		.READ_STAGE         (READ_STAGE),
		.FORWARD_READ_STAGE (FORWARD_READ_STAGE),
		.KNOW_PC_STAGE      (KNOW_PC_STAGE),
		.ALU_PRODUCE_STAGE  (ALU_PRODUCE_STAGE),
		.MEM_PRODUCE_STAGE  (MEM_PRODUCE_STAGE)
	) u_stage_file (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.cmd      (cmd),
		.move     (move),
		.valid    (stage_valid),
		.last_seq (last_seq),
		.status   (status)
	);

	phtm_seq #(
		.STAGES             (STAGES),
		.READ_STAGE         (READ_STAGE),
		.FORWARD_READ_STAGE (FORWARD_READ_STAGE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_cmd    (s_tuser),
		.s_instr  (s_instr),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.valid    (stage_valid),
		.last_seq (last_seq),
		.status   (status),
		.cmd      (cmd),
		.move     (move)
	);

	// Once a beat is taken the block is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// Only occupied stages can be scheduled to move or retire.
	a_move_valid_only: assert property (@(posedge clk) disable iff (!arst_n)
		(move & ~stage_valid) == '0)
		else $error("move scheduled for an empty stage");

	// The pipeline does not change while the block waits for a beat.
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |=> $stable(stage_valid))
		else $error("stage occupancy changed while idle");

	// A new instruction enters only into a first stage that is empty or being vacated.
	a_enter_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enter |-> (!stage_valid[0] || move[0]))
		else $error("instruction entered an occupied first stage");

endmodule

`default_nettype wire
